### hdl/wsp_pkg.sv
// shared types and constants for the wildcard star pattern matcher
// item codes, result status codes, the queued item record and store sizes
// no dependencies
package wsp_pkg;

    // pattern store depth; the active set spans positions 0..PAT_MAX
    localparam int PAT_MAX = 32;

    // depth of the queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] DOT_BYTE  = 8'h2E;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_SUBJECT = 2'd2,
        CMD_REPORT  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_CHECKED  = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_BAD_WILD = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    // classified item as it travels from front to back
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] symbol;
        logic       is_star;
        logic       is_dot;
    } item_t;

endpackage

### hdl/wsp_front.sv
// front stage: accepts input items and classifies the symbol byte
// registers one classified item for the queue; uses wsp_pkg
module wsp_front
    import wsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic [1:0] s_tuser,   // [1:0] command
    output logic       item_valid,
    input  logic       item_ready,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;

    assign s_tready = !valid_reg || item_ready;

    always_comb
    begin
        item_next.cmd     = cmd_t'(s_tuser);
        item_next.symbol  = s_tdata;
        item_next.is_star = (s_tdata == STAR_BYTE);
        item_next.is_dot  = (s_tdata == DOT_BYTE);
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### hdl/wsp_queue.sv
// short queue of classified items between front and back
// flip-flop ring with read and write pointers; uses wsp_pkg
module wsp_queue
    import wsp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    item_t              slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointers wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hdl/wsp_back.sv
// back end: pattern store, active position set and result register
// carries out one queued item per cycle while no held result blocks an end item; uses wsp_pkg
module wsp_back
    import wsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  item_t      item,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] matched, [2:1] status
);

    // skip closure: v[q] = seed[q] | prop[q] & v[q-2], done as a log-depth scan
    function automatic logic [PAT_MAX:0] close_set(
        input logic [PAT_MAX:0] seed,
        input logic [PAT_MAX:0] prop
    );
        logic [PAT_MAX:0] g;
        logic [PAT_MAX:0] p;
        logic [PAT_MAX:0] gn;
        logic [PAT_MAX:0] pn;
        int               off;
        g = seed;
        p = prop;
        for (int k = 0; k < $clog2(PAT_MAX + 1); k++)
        begin
            off = 2 << k;
            gn  = g;
            pn  = p;
            for (int q = 0; q <= PAT_MAX; q++)
            begin
                if (q >= off)
                begin
                    gn[q] = g[q] | (p[q] & g[q - off]);
                    pn[q] = p[q] & p[q - off];
                end
            end
            g = gn;
            p = pn;
        end
        return g;
    endfunction

    logic [7:0]       pat_reg [PAT_MAX];
    logic [PAT_MAX-1:0] star_reg;
    logic [PAT_MAX-1:0] dot_reg;
    logic [PAT_MAX-1:0] len_reg;      // thermometer: bit i set while i < count
    logic [PAT_MAX-1:0] len_next;
    logic [PAT_MAX:0]   end_reg;      // one-hot at the pattern count
    logic [PAT_MAX:0]   end_next;
    logic [PAT_MAX:0]   active_reg;
    logic [PAT_MAX:0]   active_next;
    logic               restart_reg;  // active set is the closed start set
    logic               restart_next;
    logic               last_star_reg;
    logic               last_star_next;
    logic               malformed_reg;
    logic               malformed_next;
    logic               overflow_reg;
    logic               overflow_next;
    logic               seen_reg;
    logic               seen_next;
    logic               wild_reg;
    logic               wild_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_matched_reg;
    logic               out_matched_next;
    status_t            out_status_reg;
    status_t            out_status_next;

    logic [PAT_MAX:0]   star_ext;
    logic [PAT_MAX-1:0] skip;
    logic [PAT_MAX+1:0] skip_sh;
    logic [PAT_MAX:0]   prop;
    logic [PAT_MAX:0]   start_set;
    logic [PAT_MAX:0]   active_eff;
    logic [PAT_MAX:0]   stepped;
    logic [PAT_MAX:0]   stepped_closed;
    logic               hit;
    logic               full;
    logic               out_ready;
    logic               pop;
    logic               do_write;
    status_t            status;

    // position pos is starred when the next stored byte is a star
    always_comb
    begin
        star_ext = {1'b0, star_reg & len_reg};
        for (int pos = 0; pos < PAT_MAX; pos++)
        begin
            skip[pos] = star_ext[pos + 1];
        end
        skip_sh   = {skip, 2'b00};
        prop      = skip_sh[PAT_MAX:0];
        start_set = close_set((PAT_MAX + 1)'(1), prop);
        active_eff = restart_reg ? start_set : active_reg;
    end

    // one subject byte through the automaton
    always_comb
    begin
        stepped = '0;
        hit     = 1'b0;
        for (int pos = 0; pos < PAT_MAX; pos++)
        begin
            hit = active_eff[pos] & len_reg[pos] & ~star_reg[pos]
                & (dot_reg[pos] | (pat_reg[pos] == item.symbol));
            stepped[pos]     = stepped[pos] | (hit & skip[pos]);
            stepped[pos + 1] = stepped[pos + 1] | (hit & ~skip[pos]);
        end
        stepped_closed = close_set(stepped, prop);
    end

    assign full      = end_reg[PAT_MAX];
    assign out_ready = !out_valid_reg || m_tready;
    assign item_ready = (item.cmd != CMD_REPORT) || out_ready;
    assign pop       = item_valid && item_ready;
    assign do_write  = pop && (item.cmd == CMD_APPEND) && !full;

    always_comb
    begin
        if (!seen_reg || end_reg[0])
        begin
            status = ST_EMPTY;
        end
        else if (overflow_reg)
        begin
            status = ST_OVERFLOW;
        end
        else if (malformed_reg || wild_reg)
        begin
            status = ST_BAD_WILD;
        end
        else
        begin
            status = ST_CHECKED;
        end
    end

    always_comb
    begin
        len_next         = len_reg;
        end_next         = end_reg;
        active_next      = active_reg;
        restart_next     = restart_reg;
        last_star_next   = last_star_reg;
        malformed_next   = malformed_reg;
        overflow_next    = overflow_reg;
        seen_next        = seen_reg;
        wild_next        = wild_reg;
        out_matched_next = out_matched_reg;
        out_status_next  = out_status_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        if (pop)
        begin
            case (item.cmd)
                CMD_CLEAR:
                begin
                    len_next       = '0;
                    end_next       = (PAT_MAX + 1)'(1);
                    last_star_next = 1'b0;
                    malformed_next = 1'b0;
                    overflow_next  = 1'b0;
                    restart_next   = 1'b1;
                    seen_next      = 1'b0;
                    wild_next      = 1'b0;
                end
                CMD_APPEND:
                begin
                    if (full)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        if (item.is_star && (end_reg[0] || last_star_reg))
                        begin
                            malformed_next = 1'b1;
                        end
                        len_next       = {len_reg[PAT_MAX-2:0], 1'b1};
                        end_next       = {end_reg[PAT_MAX-1:0], 1'b0};
                        last_star_next = item.is_star;
                    end
                    restart_next = 1'b1;
                    seen_next    = 1'b0;
                    wild_next    = 1'b0;
                end
                CMD_SUBJECT:
                begin
                    seen_next    = 1'b1;
                    wild_next    = wild_reg | item.is_star | item.is_dot;
                    active_next  = stepped_closed;
                    restart_next = 1'b0;
                end
                CMD_REPORT:
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = status;
                    out_matched_next = (status == ST_CHECKED) && |(active_eff & end_reg);
                    restart_next     = 1'b1;
                    seen_next        = 1'b0;
                    wild_next        = 1'b0;
                end
                default:
                begin
                    restart_next = restart_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            end_reg       <= (PAT_MAX + 1)'(1);
            restart_reg   <= 1'b1;
            last_star_reg <= 1'b0;
            malformed_reg <= 1'b0;
            overflow_reg  <= 1'b0;
            seen_reg      <= 1'b0;
            wild_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            end_reg       <= end_next;
            restart_reg   <= restart_next;
            last_star_reg <= last_star_next;
            malformed_reg <= malformed_next;
            overflow_reg  <= overflow_next;
            seen_reg      <= seen_next;
            wild_reg      <= wild_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: pattern entries, active set, result fields
    always_ff @(posedge clk)
    begin
        active_reg      <= active_next;
        out_matched_reg <= out_matched_next;
        out_status_reg  <= out_status_next;
        for (int i = 0; i < PAT_MAX; i++)
        begin
            if (do_write && end_reg[i])
            begin
                pat_reg[i]  <= item.symbol;
                star_reg[i] <= item.is_star;
                dot_reg[i]  <= item.is_dot;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_status_reg, out_matched_reg};

    a_count_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(end_reg))
        else $error("pattern count marker not one-hot");

    a_match_needs_check: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_matched_reg |-> out_status_reg == ST_CHECKED)
        else $error("match reported with a non-clean status");

    a_overflow_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(overflow_reg) |-> end_reg[PAT_MAX])
        else $error("overflow flagged while store not full");

    a_report_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        pop && item.cmd == CMD_REPORT |=> restart_reg && !seen_reg)
        else $error("report did not restart the subject");

endmodule

### hdl/wildcard_star_pattern_matcher.sv
// top level of the wildcard star pattern matcher
// front stage, item queue and matching back end; uses wsp_pkg
//
// usage
//   s_* carries one item per accept: s_tuser is the command (clear pattern,
//   append pattern byte, subject byte, end of subject) and s_tdata the byte.
//   pattern bytes are appended first; '.' matches any byte and '*' repeats
//   the element before it. subject bytes then stream in and an end item
//   yields one result item on m_*: m_tdata[0] matched, m_tdata[2:1] status
//   (checked, empty subject or pattern, misplaced star or wildcard byte in
//   the subject, overflow). clear, append and subject items give no result.
// throughput: one item per cycle, any command mix, while not stalled; the
//   active position set is updated for all pattern positions in parallel
//   in the back end
// path to m_tvalid: front register, queue slot, result register
// stall: a held result stalls the back end once an end item reaches it;
//   items ahead of it still drain, and the four queue slots and the front
//   register fill before s_tready drops
// reset: pattern empty, subject restarted, no result pending; pattern store
//   entries hold no reset value and are only read below the pattern count
module wildcard_star_pattern_matcher
    import wsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic [1:0] s_tuser,   // [1:0] command
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] matched, [2:1] status, [7:3] zero
);

    // front register to queue
    logic  fr_valid;
    logic  fr_ready;
    item_t fr_item;

    // queue to back end
    logic  bk_valid;
    logic  bk_ready;
    item_t bk_item;

    wsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (fr_valid),
        .item_ready (fr_ready),
        .item       (fr_item)
    );

    // decouples the back end so a stalled result does not stop the front
    wsp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_item  (fr_item),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_item   (bk_item)
    );

    wsp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (bk_valid),
        .item_ready (bk_ready),
        .item       (bk_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

### tb/sv/tb_wildcard_star_pattern_matcher.sv
// testbench for the wildcard star pattern matcher: directed and random item streams
// a predictor tracks the pattern store and active position set; depends on wsp_pkg and the rtl
module tb_wildcard_star_pattern_matcher;
    import wsp_pkg::*;

    // cycles with no accept on either side before the run is declared hung
    localparam int QUIET_LIMIT = 2000;
    // settle time after the last result
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] symbol;
    } stim_t;

    typedef struct packed {
        logic    matched;
        status_t status;
    } verdict_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;     // [7:0] symbol
    logic [1:0] s_tuser = CMD_CLEAR; // [1:0] command
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;             // [0] matched, [2:1] status

    stim_t    stim_q[$];    // items still to be offered, front is on the bus
    verdict_t verdict_q[$]; // results predicted but not yet seen
    int       accepted = 0;
    int       results_seen = 0;
    int       errors = 0;
    int       quiet = 0;

    // predictor state: pattern store, live positions and the sticky marks
    logic [7:0]       pat_mem [PAT_MAX];
    int               pat_len = 0;
    logic [PAT_MAX:0] live = {{PAT_MAX{1'b0}}, 1'b1};
    bit               subj_seen = 0;
    bit               subj_wild = 0;
    bit               malformed = 0;
    bit               overflowed = 0;

    wildcard_star_pattern_matcher i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // element at p is followed by a stored star
    function automatic bit is_starred(int p);
        return (p + 1 < pat_len) && (pat_mem[p + 1] == STAR_BYTE);
    endfunction

    // add every position reachable by skipping starred elements, left to right
    function automatic logic [PAT_MAX:0] skip_closure(logic [PAT_MAX:0] s);
        for (int p = 0; p < pat_len; p++) begin
            if (s[p] && is_starred(p) && p + 2 <= pat_len)
                s[p + 2] = 1'b1;
        end
        return s;
    endfunction

    function automatic void restart_subject();
        live = skip_closure({{PAT_MAX{1'b0}}, 1'b1});
        subj_seen = 0;
        subj_wild = 0;
    endfunction

    // apply one accepted item to the predictor, queue a result for an end item
    function automatic void advance_matcher(cmd_t cmd, logic [7:0] sym);
        logic [PAT_MAX:0] nxt;
        verdict_t v;
        case (cmd)
            CMD_CLEAR:
            begin
                pat_len = 0;
                malformed = 0;
                overflowed = 0;
                restart_subject();
            end
            CMD_APPEND:
            begin
                if (pat_len >= PAT_MAX) begin
                    overflowed = 1;
                end
                else begin
                    if (sym == STAR_BYTE && (pat_len == 0 || pat_mem[pat_len - 1] == STAR_BYTE))
                        malformed = 1;
                    pat_mem[pat_len] = sym;
                    pat_len++;
                end
                restart_subject();
            end
            CMD_SUBJECT:
            begin
                subj_seen = 1;
                if (sym == STAR_BYTE || sym == DOT_BYTE)
                    subj_wild = 1;
                nxt = '0;
                for (int p = 0; p < pat_len; p++) begin
                    if (live[p] && pat_mem[p] != STAR_BYTE &&
                        (pat_mem[p] == DOT_BYTE || pat_mem[p] == sym)) begin
                        if (is_starred(p))
                            nxt[p] = 1'b1;
                        else
                            nxt[p + 1] = 1'b1;
                    end
                end
                live = skip_closure(nxt);
            end
            default:
            begin
                if (!subj_seen || pat_len == 0)
                    v.status = ST_EMPTY;
                else if (overflowed)
                    v.status = ST_OVERFLOW;
                else if (malformed || subj_wild)
                    v.status = ST_BAD_WILD;
                else
                    v.status = ST_CHECKED;
                v.matched = (v.status == ST_CHECKED) && live[pat_len];
                verdict_q.push_back(v);
                restart_subject();
            end
        endcase
    endfunction

    // idles with a chance of 12 in a hundred, never while the quiet window is open
    function automatic bit take_idle();
        if (accepted >= 800 && accepted < 1100)
            return 0;
        return $urandom_range(0, 99) < 12;
    endfunction

    function automatic logic [7:0] pick_letter();
        return 8'h61 + 8'($urandom_range(0, 2));
    endfunction

    task automatic push(cmd_t cmd, logic [7:0] sym);
        stim_t s;
        s.cmd = cmd;
        s.symbol = sym;
        stim_q.push_back(s);
    endtask

    // driver: holds an item until accepted, then offers the next one or idles
    always @(posedge clk or negedge rst_n) begin : drive
        bit hold;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'h00;
            s_tuser <= CMD_CLEAR;
        end
        else begin
            hold = s_tvalid && !s_tready;
            if (s_tvalid && s_tready) begin
                advance_matcher(cmd_t'(s_tuser), s_tdata);
                void'(stim_q.pop_front());
                accepted++;
            end
            if (!hold) begin
                if (stim_q.size() > 0 && !take_idle()) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= stim_q[0].symbol;
                    s_tuser <= stim_q[0].cmd;
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result item against the oldest prediction
    always @(posedge clk or negedge rst_n) begin : watch
        verdict_t want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, %s",
                             $time, "got");
                    $display("    matched=%0b status=%0d", m_tdata[0], m_tdata[2:1]);
                    errors++;
                end
                else begin
                    want = verdict_q.pop_front();
                    if (m_tdata[0] !== want.matched || m_tdata[2:1] !== want.status) begin
                        $display({"%0t: result %0d expected matched=%0b status=%0d, ",
                                  "got matched=%0b status=%0d"},
                                 $time, results_seen, want.matched, want.status,
                                 m_tdata[0], m_tdata[2:1]);
                        errors++;
                    end
                end
                results_seen++;
            end
            m_tready <= !take_idle();
        end
    end

    // watchdog: counts cycles in which neither side moves an item
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("wildcard_star_pattern_matcher: mismatch");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [7:0] pat_gen[$];
        logic [7:0] subj[$];
        logic [7:0] b;
        int n_pat;
        int n_subj;
        int rep;
        int r;

        // directed: empty pattern and subject, then "a.*b"
        push(CMD_REPORT, 8'h00);
        push(CMD_APPEND, 8'h61);
        push(CMD_REPORT, 8'hFF);      // pattern but no subject
        push(CMD_APPEND, DOT_BYTE);
        push(CMD_APPEND, STAR_BYTE);
        push(CMD_APPEND, 8'h62);
        push(CMD_SUBJECT, 8'h61);
        push(CMD_SUBJECT, 8'hFF);
        push(CMD_SUBJECT, 8'h62);
        push(CMD_REPORT, 8'h00);      // match
        push(CMD_SUBJECT, 8'h61);
        push(CMD_SUBJECT, DOT_BYTE);  // wildcard in the subject
        push(CMD_REPORT, 8'h00);
        push(CMD_SUBJECT, 8'h00);
        push(CMD_APPEND, STAR_BYTE);  // append mid subject drops the subject
        push(CMD_REPORT, 8'h00);
        push(CMD_SUBJECT, STAR_BYTE);
        push(CMD_REPORT, 8'h00);
        // leading star
        push(CMD_CLEAR, 8'hFF);
        push(CMD_APPEND, STAR_BYTE);
        push(CMD_SUBJECT, 8'h61);
        push(CMD_REPORT, 8'h00);
        // doubled star
        push(CMD_CLEAR, 8'h00);
        push(CMD_APPEND, 8'h61);
        push(CMD_APPEND, STAR_BYTE);
        push(CMD_APPEND, STAR_BYTE);
        push(CMD_SUBJECT, 8'h61);
        push(CMD_REPORT, 8'h00);

        // random: mostly well formed sessions, some noise and broken patterns
        while (stim_q.size() < 1730) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                repeat ($urandom_range(1, 4))
                    push(cmd_t'($urandom_range(0, 3)), 8'($urandom));
                pat_gen.delete();
            end
            else begin
                if ($urandom_range(0, 9) != 0) begin
                    push(CMD_CLEAR, 8'($urandom));
                    pat_gen.delete();
                end
                r = $urandom_range(0, 99);
                if (r < 80)
                    n_pat = $urandom_range(1, 8);
                else if (r < 92)
                    n_pat = $urandom_range(9, PAT_MAX);
                else
                    n_pat = $urandom_range(PAT_MAX + 1, PAT_MAX + 4);
                for (int i = 0; i < n_pat; i++) begin
                    if ($urandom_range(0, 99) < 4)
                        b = STAR_BYTE;    // may land first or after a star
                    else if (pat_gen.size() > 0 && pat_gen[$] != STAR_BYTE &&
                             $urandom_range(0, 99) < 30)
                        b = STAR_BYTE;
                    else begin
                        r = $urandom_range(0, 99);
                        if (r < 70)
                            b = pick_letter();
                        else if (r < 85)
                            b = DOT_BYTE;
                        else
                            b = 8'($urandom);
                    end
                    pat_gen.push_back(b);
                    push(CMD_APPEND, b);
                end
                n_subj = $urandom_range(1, 4);
                for (int k = 0; k < n_subj; k++) begin
                    subj.delete();
                    if ($urandom_range(0, 1) == 0) begin
                        // expand the pattern into a subject that should match
                        for (int i = 0; i < pat_gen.size() && subj.size() < 20; i++) begin
                            if (pat_gen[i] == STAR_BYTE)
                                continue;
                            if (i + 1 < pat_gen.size() && pat_gen[i + 1] == STAR_BYTE)
                                rep = $urandom_range(0, 3);
                            else
                                rep = 1;
                            repeat (rep)
                                subj.push_back(pat_gen[i] == DOT_BYTE ? pick_letter() : pat_gen[i]);
                        end
                        if (subj.size() > 0 && $urandom_range(0, 3) == 0)
                            subj[$urandom_range(0, subj.size() - 1)] = pick_letter();
                    end
                    else begin
                        repeat ($urandom_range(0, 8))
                            subj.push_back(pick_letter());
                    end
                    r = $urandom_range(0, 99);
                    if (r < 5 && subj.size() > 0)
                        subj[$urandom_range(0, subj.size() - 1)] =
                            ($urandom_range(0, 1) != 0) ? DOT_BYTE : STAR_BYTE;
                    else if (r < 10 && subj.size() > 0)
                        subj[$urandom_range(0, subj.size() - 1)] = 8'($urandom);
                    foreach (subj[j])
                        push(CMD_SUBJECT, subj[j]);
                    if ($urandom_range(0, 19) == 0) begin
                        // extend the pattern mid subject, which restarts it
                        b = pick_letter();
                        pat_gen.push_back(b);
                        push(CMD_APPEND, b);
                    end
                    push(CMD_REPORT, 8'($urandom));
                end
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() > 0 || verdict_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && verdict_q.size() == 0)
            $display("wildcard_star_pattern_matcher: match");
        else
            $display("wildcard_star_pattern_matcher: mismatch");
        $finish;
    end

endmodule
